### design/irrigation_pump_volume_controller_top_macros.svh
// Assertion macros for the irrigation pump volume controller checker.
`ifndef IRRIGATION_PUMP_VOLUME_CONTROLLER_TOP_MACROS_SVH
`define IRRIGATION_PUMP_VOLUME_CONTROLLER_TOP_MACROS_SVH

// Checked at every clock edge outside of reset.
`define IPVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IPVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ipvc_pkg.sv
// Shared types and constants for the irrigation pump volume controller.
package ipvc_pkg;

    localparam int unsigned CAL_W    = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned VOL_W    = 16;
    localparam int unsigned PLANT_W  = 8;
    localparam int unsigned PULSE_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CAL_W-1:0]  CAL_RST     = 8'd9;
    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd300000;
    localparam logic [TIME_W-1:0] DRY_RST     = 32'd10000;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_PULSE = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_STOP  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        WHY_NONE    = 3'd0,
        WHY_TARGET  = 3'd1,
        WHY_TIMEOUT = 3'd2,
        WHY_DRY     = 3'd3,
        WHY_CMD     = 3'd4
    } t_why;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL     = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_DRY     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CAL_W-1:0]  cal;
        logic [TIME_W-1:0] timeout_ms;
        logic [TIME_W-1:0] dry_ms;
    } t_cfg;

    typedef struct packed {
        logic [VOL_W-1:0]   volume_req_ml;
        logic [PLANT_W-1:0] plant_sel;
        logic [TIME_W-1:0]  now_ms;
        t_req               req_type;
    } t_item;

    typedef struct packed {
        logic               start_ignored;
        t_why               stop_reason;
        logic [PLANT_W-1:0] active_plant;
        logic [VOL_W-1:0]   delivered_ml;
        logic               pump_on;
    } t_result;

endpackage

### design/irrigation_pump_volume_controller_top.sv
// Top level of the irrigation pump volume controller.
//
//  channel | direction | payload
//  s       | in        | tuser[1:0] req_type; tdata now_ms, plant_sel, volume_req_ml
//  m       | out       | tdata pump_on, delivered_ml, active_plant, stop_reason,
//          |           |       start_ignored
//  cfg     | in        | index 0 calibration, 1 run timeout, 2 dry window
//
// One beat per cycle on s and m while m is not stalled; a result passes the input
// register, then the result register. The pump state updates with the result.
// Reset is synchronous and active low; it stops the pump, clears the counters and
// loads calibration 9, timeout 300000 ms and dry window 10000 ms.
// A stall on m holds the result; s keeps taking beats while the input register is free.
module irrigation_pump_volume_controller_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [55:0]                      i_s_tdata,   // now_ms, plant_sel, volume_req_ml
    input  logic [1:0]                       i_s_tuser,   // req_type
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // pump_on, delivered_ml, active_plant, stop_reason, start_ignored, zero pad
    output logic [31:0]                      o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ipvc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ipvc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ipvc_pkg::*;

    t_cfg    w_cfg;
    t_item   w_in_item;
    t_item   w_item;
    logic    w_valid;
    logic    w_take;
    t_result w_result;

    assign w_in_item.req_type      = t_req'(i_s_tuser);
    assign w_in_item.now_ms        = i_s_tdata[31:0];
    assign w_in_item.plant_sel     = i_s_tdata[39:32];
    assign w_in_item.volume_req_ml = i_s_tdata[55:40];

    ipvc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ipvc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_item     (w_in_item),
        .i_take     (w_take),
        .o_valid    (w_valid),
        .o_item     (w_item)
    );

    ipvc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_take     (w_take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (w_result)
    );

    assign o_m_tdata = {3'b000, w_result.start_ignored, w_result.stop_reason,
                        w_result.active_plant, w_result.delivered_ml, w_result.pump_on};

endmodule

### design/ipvc_cfg_regs.sv
// Calibration, timeout and dry window registers.
module ipvc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ipvc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ipvc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ipvc_pkg::t_cfg                   o_cfg
);
    import ipvc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CAL:     n_cfg.cal        = i_cfg_data[CAL_W-1:0];
                CFG_TIMEOUT: n_cfg.timeout_ms = i_cfg_data[TIME_W-1:0];
                CFG_DRY:     n_cfg.dry_ms     = i_cfg_data[TIME_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal        <= CAL_RST;
            r_cfg.timeout_ms <= TIMEOUT_RST;
            r_cfg.dry_ms     <= DRY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### design/ipvc_in_stage.sv
// Input register: holds one accepted beat until the core takes it.
module ipvc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  ipvc_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_valid,
    output ipvc_pkg::t_item o_item
);
    import ipvc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign o_s_tready = !r_valid || i_take;
    assign w_load     = i_s_tvalid && o_s_tready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule

### design/ipvc_core.sv
// Pump state, volume and stop decision, and the result register.
module ipvc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipvc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  ipvc_pkg::t_item   i_item,
    output logic              o_take,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output ipvc_pkg::t_result o_result
);
    import ipvc_pkg::*;

    localparam int unsigned PROD_W = PULSE_W + CAL_W;

    logic               r_running;
    logic [VOL_W-1:0]   r_target;
    logic [VOL_W-1:0]   r_delivered;
    logic [TIME_W-1:0]  r_start;
    logic [PLANT_W-1:0] r_plant;
    logic [PULSE_W-1:0] r_pulses;
    logic               r_out_valid;
    t_result            r_out;

    logic               n_running;
    logic [VOL_W-1:0]   n_target;
    logic [VOL_W-1:0]   n_delivered;
    logic [TIME_W-1:0]  n_start;
    logic [PLANT_W-1:0] n_plant;
    logic [PULSE_W-1:0] n_pulses;
    t_result            n_out;

    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W-3:0]  w_quarter;
    logic [VOL_W-1:0]   w_volume;
    logic [TIME_W-1:0]  w_elapsed;
    t_why               w_why;
    logic               w_ignored;
    logic               w_fire;

    assign o_take     = !r_out_valid || i_m_tready;
    assign w_fire     = i_valid && o_take;
    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

    // quarter-ml product, divide by four, saturate to 16 bits
    assign w_prod    = {{CAL_W{1'b0}}, r_pulses} * {{PULSE_W{1'b0}}, i_cfg.cal};
    assign w_quarter = w_prod[PROD_W-1:2];
    assign w_volume  = (|w_quarter[PROD_W-3:VOL_W]) ? {VOL_W{1'b1}} : w_quarter[VOL_W-1:0];
    assign w_elapsed = i_item.now_ms - r_start;

    always_comb begin
        n_running   = r_running;
        n_target    = r_target;
        n_delivered = r_delivered;
        n_start     = r_start;
        n_plant     = r_plant;
        n_pulses    = r_pulses;
        w_why       = WHY_NONE;
        w_ignored   = 1'b0;
        unique case (i_item.req_type)
            REQ_START: begin
                if (r_running) begin
                    w_ignored = 1'b1;
                end else begin
                    n_running   = 1'b1;
                    n_plant     = i_item.plant_sel;
                    n_target    = i_item.volume_req_ml;
                    n_delivered = '0;
                    n_start     = i_item.now_ms;
                    n_pulses    = '0;
                end
            end
            REQ_PULSE: begin
                n_pulses = r_pulses + 1'b1;
            end
            REQ_CHECK: begin
                if (r_running) begin
                    n_delivered = w_volume;
                    priority if (w_volume >= r_target) begin
                        w_why = WHY_TARGET;
                    end else if (w_elapsed > i_cfg.timeout_ms) begin
                        w_why = WHY_TIMEOUT;
                    end else if (w_elapsed > i_cfg.dry_ms && r_pulses == '0) begin
                        w_why = WHY_DRY;
                    end else begin
                        w_why = WHY_NONE;
                    end
                    if (w_why != WHY_NONE) begin
                        n_running = 1'b0;
                    end
                end
            end
            REQ_STOP: begin
                if (r_running) begin
                    n_running = 1'b0;
                    w_why     = WHY_CMD;
                end
            end
            default: begin
                n_running = r_running;
            end
        endcase

        n_out.pump_on       = n_running;
        n_out.delivered_ml  = n_delivered;
        n_out.active_plant  = n_plant;
        n_out.stop_reason   = w_why;
        n_out.start_ignored = w_ignored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_target    <= '0;
            r_delivered <= '0;
            r_start     <= '0;
            r_plant     <= '0;
            r_pulses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_running   <= n_running;
                r_target    <= n_target;
                r_delivered <= n_delivered;
                r_start     <= n_start;
                r_plant     <= n_plant;
                r_pulses    <= n_pulses;
            end
            if (o_take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule

### design/ipvc_checker.sv
// Port-level checks for the irrigation pump volume controller, bound to the top.
`include "irrigation_pump_volume_controller_top_macros.svh"

module ipvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);
    import ipvc_pkg::*;

    // result stalled on m holds its beat
    `IPVC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // a beat that reports a stop shows the pump off
    `IPVC_ASSERT(a_stop_off, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[27:25] != WHY_NONE) |-> !o_m_tdata[0], "stop reported with pump on")

    // an ignored start only happens while running, and stops nothing
    `IPVC_ASSERT(a_ign_run, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[28] |-> o_m_tdata[0] && (o_m_tdata[27:25] == WHY_NONE), "ignored start while idle")

    // reset empties the result register
    `IPVC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind irrigation_pump_volume_controller_top ipvc_checker u_ipvc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
